@@ src/assert_macros.svh @@
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that b holds in the same cycle whenever a holds.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("implication check failed");

// Checks that b holds in the cycle after a holds.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

@@ src/frp_pkg.sv @@
// Package with types, constants and codes of the fragment reassembly receiver.
package frp_pkg;

	localparam int BUFFER_BYTES = 128;
	localparam int FRAG_BYTES = 16;
	localparam int STORE_WORDS = (BUFFER_BYTES + 7) / 8;
	localparam int POS_W = $clog2(BUFFER_BYTES + 1);
	localparam int ADDR_W = $clog2(STORE_WORDS);

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [7:0] ACK_RESET = 8'd0;

	localparam logic [2:0] ST_ACCEPT = 3'd0;
	localparam logic [2:0] ST_ACK = 3'd1;
	localparam logic [2:0] ST_WORD = 3'd2;
	localparam logic [2:0] ST_FAIL = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;
	localparam logic [2:0] ST_IDLE = 3'd5;

	localparam logic OP_FRAG = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] CH_START = 2'd0;
	localparam logic [1:0] CH_MIDDLE = 2'd1;
	localparam logic [1:0] CH_END = 2'd2;

	localparam logic REG_ACK = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic operation;
		logic [1:0] channel;
		logic [15:0] total_length;
		logic [63:0] payload_lo;
		logic [63:0] payload_hi;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [63:0] data_word;
		logic [3:0] word_index;
		logic [7:0] message_length;
		logic last_word;
	} out_t;

	typedef struct packed {
		logic [7:0] ack_code;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic store;
		logic deliver;
		logic [ADDR_W-1:0] waddr;
		logic [POS_W-1:0] len;
		logic [63:0] payload_lo;
		logic [63:0] payload_hi;
	} cmd_t;

endpackage

@@ src/frp_front.sv @@
// Front part: accepts items, keeps reassembly and timer state, issues commands.
module frp_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input frp_pkg::in_t item,
	input frp_pkg::cfg_t cfg,
	input logic q_full,
	output logic cmd_push,
	output frp_pkg::cmd_t cmd
);
	import frp_pkg::*;

	logic [POS_W-1:0] wp_q, wp_n;
	logic [POS_W-1:0] exp_q, exp_n;
	logic [15:0] tcnt_q, tcnt_n;
	logic trun_q, trun_n;
	logic accept;
	logic [POS_W:0] wp_sum;
	logic fits;
	logic [15:0] tcnt_inc;
	logic [15:0] limit;

	assign accept = push && !q_full;
	assign full = q_full;
	assign cmd_push = accept;

	assign wp_sum = {1'b0, wp_q} + (POS_W + 1)'(FRAG_BYTES);
	assign fits = wp_sum <= (POS_W + 1)'(BUFFER_BYTES);
	assign tcnt_inc = tcnt_q + 16'd1;
	assign limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;

	always_comb begin
		wp_n = wp_q;
		exp_n = exp_q;
		tcnt_n = tcnt_q;
		trun_n = trun_q;
		cmd.status = ST_IDLE;
		cmd.store = 1'b0;
		cmd.deliver = 1'b0;
		cmd.waddr = wp_q[ADDR_W+2:3];
		cmd.len = exp_q;
		cmd.payload_lo = item.payload_lo;
		cmd.payload_hi = item.payload_hi;
		if (item.operation == OP_TICK) begin
			if (trun_q) begin
				tcnt_n = tcnt_inc;
				if (tcnt_inc >= limit) begin
					cmd.status = ST_FAIL;
					wp_n = '0;
					exp_n = POS_W'(BUFFER_BYTES);
					tcnt_n = '0;
					trun_n = 1'b0;
				end
			end
		end else if (item.channel == CH_START) begin
			if (item.payload_lo[7:0] == cfg.ack_code) begin
				cmd.status = ST_ACK;
			end else if (item.total_length > 16'(BUFFER_BYTES)) begin
				cmd.status = ST_FAIL;
				wp_n = '0;
				exp_n = POS_W'(BUFFER_BYTES);
				tcnt_n = '0;
				trun_n = 1'b0;
			end else begin
				cmd.status = ST_ACCEPT;
				cmd.store = 1'b1;
				cmd.waddr = '0;
				wp_n = POS_W'(FRAG_BYTES);
				exp_n = item.total_length[POS_W-1:0];
				tcnt_n = '0;
				trun_n = 1'b1;
			end
		end else if (item.channel != CH_MIDDLE && item.channel != CH_END) begin
			cmd.status = ST_REJECT;
		end else if (wp_q == '0) begin
			cmd.status = ST_REJECT;
		end else if (!fits) begin
			cmd.status = ST_FAIL;
			wp_n = '0;
			exp_n = POS_W'(BUFFER_BYTES);
			tcnt_n = '0;
			trun_n = 1'b0;
		end else if (item.channel == CH_MIDDLE) begin
			cmd.status = ST_ACCEPT;
			cmd.store = 1'b1;
			wp_n = wp_sum[POS_W-1:0];
			tcnt_n = '0;
			trun_n = 1'b1;
		end else begin
			cmd.store = 1'b1;
			cmd.status = ST_FAIL;
			if (wp_sum >= {1'b0, exp_q}) begin
				cmd.status = ST_WORD;
				cmd.deliver = 1'b1;
			end
			wp_n = '0;
			exp_n = POS_W'(BUFFER_BYTES);
			tcnt_n = '0;
			trun_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			exp_q <= POS_W'(BUFFER_BYTES);
			tcnt_q <= '0;
			trun_q <= 1'b0;
		end else if (accept) begin
			wp_q <= wp_n;
			exp_q <= exp_n;
			tcnt_q <= tcnt_n;
			trun_q <= trun_n;
		end
	end

endmodule

@@ src/frp_cmd_fifo.sv @@
// Two-entry command queue between the front and back parts.
module frp_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input frp_pkg::cmd_t wdata,
	output logic full,
	input logic pop,
	output logic valid,
	output frp_pkg::cmd_t rdata
);
	import frp_pkg::*;

	cmd_t ent_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign rdata = ent_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= !wptr_q;
			end
			if (do_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

@@ src/frp_back.sv @@
// Back part: writes fragments to the message store, drains messages, queues results.
module frp_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input frp_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input logic pop,
	output frp_pkg::out_t result
);
	import frp_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_WR_HI = 3'd1;
	localparam logic [2:0] B_STAT = 3'd2;
	localparam logic [2:0] B_RD = 3'd3;
	localparam logic [2:0] B_OUT = 3'd4;

	logic [2:0] state_q, state_n;
	logic [ADDR_W-1:0] k_q, k_n;
	cmd_t cur_q;
	logic [63:0] mem [STORE_WORDS];
	logic [63:0] rd_q;
	logic we;
	logic [ADDR_W-1:0] wa;
	logic [63:0] wd;
	logic re;
	logic [ADDR_W-1:0] last_idx;
	logic [63:0] mask;
	logic res_push;
	out_t res_data;

	out_t ent_q [2];
	logic owptr_q, orptr_q;
	logic [1:0] ocnt_q;
	logic ofull, do_opop;

	assign last_idx = (cur_q.len == '0) ? '0 : ADDR_W'((cur_q.len - POS_W'(1)) >> 3);

	always_comb begin
		mask = '1;
		if (cur_q.len == '0) begin
			mask = '0;
		end else if (k_q == last_idx && cur_q.len[2:0] != 3'd0) begin
			for (int b = 0; b < 8; b++) begin
				mask[b*8 +: 8] = (3'(b) < cur_q.len[2:0]) ? 8'hFF : 8'h00;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		k_n = k_q;
		cmd_pop = 1'b0;
		we = 1'b0;
		wa = cmd.waddr;
		wd = cmd.payload_lo;
		re = 1'b0;
		res_push = 1'b0;
		res_data = '0;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.store) begin
						we = 1'b1;
						state_n = B_WR_HI;
					end else begin
						state_n = B_STAT;
					end
				end
			end
			B_WR_HI: begin
				we = 1'b1;
				wa = cur_q.waddr + ADDR_W'(1);
				wd = cur_q.payload_hi;
				k_n = '0;
				state_n = cur_q.deliver ? B_RD : B_STAT;
			end
			B_STAT: begin
				res_data.status = cur_q.status;
				if (!ofull) begin
					res_push = 1'b1;
					state_n = B_IDLE;
				end
			end
			B_RD: begin
				re = 1'b1;
				state_n = B_OUT;
			end
			B_OUT: begin
				res_data.status = ST_WORD;
				res_data.data_word = rd_q & mask;
				res_data.word_index = 4'(k_q);
				res_data.message_length = 8'(cur_q.len);
				res_data.last_word = k_q == last_idx;
				if (!ofull) begin
					res_push = 1'b1;
					if (k_q == last_idx) begin
						state_n = B_IDLE;
					end else begin
						k_n = k_q + ADDR_W'(1);
						state_n = B_RD;
					end
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[k_q];
		end
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q <= '0;
		end else begin
			state_q <= state_n;
			k_q <= k_n;
		end
	end

	assign ofull = ocnt_q == 2'd2;
	assign empty = ocnt_q == 2'd0;
	assign result = ent_q[orptr_q];
	assign do_opop = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			ent_q[owptr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				owptr_q <= !owptr_q;
			end
			if (do_opop) begin
				orptr_q <= !orptr_q;
			end
			ocnt_q <= ocnt_q + {1'b0, res_push} - {1'b0, do_opop};
		end
	end

endmodule

@@ src/fragment_reassembly_receiver_core.sv @@
// A status result passes the command queue, the back part's command register and its
// result queue; a fragment is first written to the message store, low then high word.
// A delivered message then gives its words one at a time through the single read port
// of the message store, holding while the result queue is full. A two-entry command
// queue lets the front accept while the back part is busy. Reset is asynchronous: control
// and configuration return to their reset values, the message store is not cleared.
module fragment_reassembly_receiver_core (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input frp_pkg::in_t item,
	output logic empty,
	input logic pop,
	output frp_pkg::out_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import frp_pkg::*;

	`include "assert_macros.svh"

	cfg_t cfg_q;
	logic q_full;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_pop;
	logic cmd_valid;
	cmd_t cmd_head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, cfg_q.timeout_ticks}
		: {24'd0, cfg_q.ack_code};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_code <= ACK_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_ACK) begin
				cfg_q.ack_code <= pwdata[7:0];
			end else begin
				cfg_q.timeout_ticks <= pwdata[15:0];
			end
		end
	end

	frp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cfg(cfg_q),
		.q_full(q_full),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	frp_cmd_fifo u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(cmd_in),
		.full(q_full),
		.pop(cmd_pop),
		.valid(cmd_valid),
		.rdata(cmd_head)
	);

	frp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	`ASSERT_IMPLIES(a_word_fields_zero, clk, arst_n, !empty && result.status != ST_WORD, result.data_word == 64'd0 && result.word_index == 4'd0 && !result.last_word)
	`ASSERT_IMPLIES(a_word_in_range, clk, arst_n, !empty && result.status == ST_WORD && result.message_length != 8'd0, {1'b0, result.word_index, 3'b000} < result.message_length)
	`ASSERT_IMPLIES(a_last_word_place, clk, arst_n, !empty && result.last_word && result.message_length != 8'd0, result.word_index == 4'((result.message_length - 8'd1) >> 3))

endmodule
